>>> sv/assert_macros.svh
// Assertion helper macros used by the top level of this block.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sgm_pkg.sv
// Package for the Sobel gradient magnitude block: register indexes and widths.
// No dependencies; imported by every module of the block except sgm_line_mem.
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned IW_W   = 11;
  localparam int unsigned IH_W   = 13;
  localparam int unsigned SQ_W   = 17;

  // Line store depth; the column counter width above is sized for it.
  localparam int unsigned MAX_WIDTH = 1024;

  // Configuration register indexes.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Control group between the sequencer and a square-root unit.
  typedef struct packed {
    logic start;
  } sqrt_ctl_t;

endpackage

>>> sv/sgm_line_mem.sv
// Line store memory: holds the two previous rows, one 48-bit word per column.
// Depends on nothing; one write port and one registered read port.
`timescale 1ns / 1ps

module sgm_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 48
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Synchronous write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Synchronous read; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/sgm_grad.sv
// One channel of the 3x3 gradient: registered gx and gy and their square sum.
// Uses sgm_pkg for widths.
`timescale 1ns / 1ps

module sgm_grad (
  input  logic                   clk,
  input  logic                   load,
  input  logic [2:0][7:0]        top,
  input  logic [2:0][7:0]        mid,
  input  logic [2:0][7:0]        bot,
  output logic [7:0]             gx,
  output logic signed [8:0]      gy,
  output logic [sgm_pkg::SQ_W-1:0] sumsq
);
  import sgm_pkg::*;

  logic [9:0]         tsum [3];
  logic [7:0]         tval [3];
  logic signed [10:0] vval [3];
  logic signed [10:0] s;
  logic signed [10:0] s_adj;
  logic signed [10:0] gy_w;
  logic [7:0]         gx_w;
  logic [7:0]         gy_abs;
  logic [15:0]        gx_sq;
  logic [15:0]        gy_sq;

  // Vertical smooth and vertical difference for each window column.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsum[k] = {2'b00, top[k]} + {1'b0, mid[k], 1'b0} + {2'b00, bot[k]};
      tval[k] = tsum[k][9:2];
      vval[k] = $signed({3'b000, top[k]}) - $signed({3'b000, bot[k]});
    end
  end

  // Horizontal difference of the smoothed columns, taken as magnitude.
  assign gx_w = (tval[2] >= tval[0]) ? (tval[2] - tval[0]) : (tval[0] - tval[2]);

  // Horizontal smooth of the differences, divided by four toward zero.
  assign s     = vval[0] + (vval[1] <<< 1) + vval[2];
  assign s_adj = s[10] ? (s + 11'sd3) : s;
  assign gy_w  = s_adj >>> 2;

  always_ff @(posedge clk) begin
    if (load) begin
      gx <= gx_w;
      gy <= gy_w[8:0];
    end
  end

  // Squares of the registered gradients.
  assign gy_abs = gy[8] ? 8'(-gy) : gy[7:0];
  assign gx_sq  = gx * gx;
  assign gy_sq  = gy_abs * gy_abs;
  assign sumsq  = {1'b0, gx_sq} + {1'b0, gy_sq};

endmodule

>>> sv/sgm_isqrt.sv
// Iterative integer square root, one result bit per cycle, saturated to 255.
// Uses sgm_pkg for the control struct and the input width.
`timescale 1ns / 1ps

module sgm_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  sgm_pkg::sqrt_ctl_t       ctl,
  input  logic [sgm_pkg::SQ_W-1:0] value,
  output logic                     busy,
  output logic [7:0]               root_sat
);
  import sgm_pkg::*;

  logic [17:0] val;
  logic [11:0] rem;
  logic [8:0]  root;
  logic [3:0]  cnt;
  logic [11:0] rem_sh;
  logic [11:0] trial;

  // One restoring step: bring down two bits, try subtracting 4*root+1.
  assign rem_sh = {rem[9:0], val[17:16]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= 4'd9;
      val  <= {1'b0, value};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[15:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[7:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[7:0], 1'b0};
      end
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign root_sat = root[8] ? 8'hFF : root[7:0];

endmodule

>>> sv/sobel_gradient_magnitude_unit.sv
// Top level of the Sobel 3x3 gradient magnitude block: sequencer, window,
// counters, output register. Uses sgm_pkg, sgm_line_mem, sgm_grad, sgm_isqrt.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   pixel   | in_valid, in_stall, chan0..chan2   | into block
//   result  | out_valid, out_stall, out_row ...  | out of block
//   config  | cfg_we, cfg_index, cfg_data        | into block
//
// A border pixel goes from the line store read straight back to idle. An
// interior pixel goes on through the square and root states, the latter waiting
// for the bit-per-cycle square root (9 steps), then done loads the result.
// A finished result sits in the output register while the next pixel enters.
// Reset is synchronous; the line store needs no clearing pass.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         chan0,
  input  logic [7:0]         chan1,
  input  logic [7:0]         chan2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_row,
  output logic [9:0]         out_col,
  output logic [7:0]         gx0,
  output logic [7:0]         gx1,
  output logic [7:0]         gx2,
  output logic signed [8:0]  gy0,
  output logic signed [8:0]  gy1,
  output logic signed [8:0]  gy2,
  output logic [7:0]         mag0,
  output logic [7:0]         mag1,
  output logic [7:0]         mag2,
  output logic               frame_end,
  input  logic               cfg_we,
  input  sgm_pkg::reg_idx_t  cfg_index,
  input  logic [12:0]        cfg_data
);
  import sgm_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SQ   = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [IW_W-1:0]    iw;
  logic [IH_W-1:0]    ih;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [PIX_W-1:0]   cur;
  logic [PIX_W-1:0]   win [6];
  logic [ROW_W-1:0]   pend_row;
  logic [COL_W-1:0]   pend_col;
  logic               pend_fe;
  logic [12:0]        wv, wlast, hv, hlast;
  logic [12:0]        col_ext;
  logic [AW-1:0]      idx;
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   top, mid;
  logic               accept, at_col_end, at_row_end, interior;
  logic [7:0]         gx_r [3];
  logic signed [8:0]  gy_r [3];
  logic [SQ_W-1:0]    sq_r [3];
  logic [7:0]         root_r [3];
  logic               busy_r [3];
  sqrt_ctl_t          sctl;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      iw <= IW_W'(640);
      ih <= IH_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  iw <= cfg_data[IW_W-1:0];
        REG_HEIGHT: ih <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Frame size in use, clamped to the supported range.
  assign wv    = (iw < 11'd3) ? 13'd3 :
                 ({2'b00, iw} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b00, iw};
  assign wlast = wv - 13'd1;
  assign hv    = (ih < 13'd3) ? 13'd3 : (ih > 13'd4096) ? 13'd4096 : ih;
  assign hlast = hv - 13'd1;

  assign col_ext    = {3'b000, col};
  assign idx        = col_ext[AW-1:0];
  assign at_col_end = col_ext >= wlast;
  assign at_row_end = {1'b0, row} >= hlast;
  assign interior   = (row >= ROW_W'(2)) && (col >= COL_W'(2));

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Line store: upper half is two rows above, lower half is the row above.
  sgm_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(2*PIX_W)) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (state == S_READ),
    .wr_addr (idx),
    .wr_data ({mid, cur})
  );
  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = interior ? S_SQ : S_IDLE;
      S_SQ:   state_next = S_ROOT;
      S_ROOT: if (!busy_r[0]) state_next = S_DONE;
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pixel capture, window shift and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (state == S_READ) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= cur;
      if (at_col_end) begin
        col <= '0;
        row <= at_row_end ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= {chan2, chan1, chan0};
    end
    if (state == S_READ) begin
      pend_row <= row - ROW_W'(1);
      pend_col <= col - COL_W'(1);
      pend_fe  <= at_row_end && at_col_end;
    end
  end

  assign sctl.start = (state == S_SQ);

  // Per-channel gradient and square root.
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [2:0][7:0] wt, wm, wb;
    assign wt = {top[8*ch +: 8], win[3][8*ch +: 8], win[0][8*ch +: 8]};
    assign wm = {mid[8*ch +: 8], win[4][8*ch +: 8], win[1][8*ch +: 8]};
    assign wb = {cur[8*ch +: 8], win[5][8*ch +: 8], win[2][8*ch +: 8]};

    sgm_grad u_grad (
      .clk   (clk),
      .load  (state == S_READ),
      .top   (wt),
      .mid   (wm),
      .bot   (wb),
      .gx    (gx_r[ch]),
      .gy    (gy_r[ch]),
      .sumsq (sq_r[ch])
    );

    sgm_isqrt u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .ctl      (sctl),
      .value    (sq_r[ch]),
      .busy     (busy_r[ch]),
      .root_sat (root_r[ch])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_row   <= pend_row;
      out_col   <= pend_col;
      frame_end <= pend_fe;
      gx0  <= gx_r[0];
      gx1  <= gx_r[1];
      gx2  <= gx_r[2];
      gy0  <= gy_r[0];
      gy1  <= gy_r[1];
      gy2  <= gy_r[2];
      mag0 <= root_r[0];
      mag1 <= root_r[1];
      mag2 <= root_r[2];
    end
  end

  // Checks.
  `AST_NEXT(a_accept_blocks, clk, rst, accept, in_stall)
  `AST_NEXT(a_sqrt_started, clk, rst, state == S_SQ, busy_r[0] && busy_r[1] && busy_r[2])
  `AST_SAME(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE))

endmodule
